FILE: src/token_bucket_rate_limiter_core_assert.svh
// Assertion macros shared by the token bucket checker.
`ifndef TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH
`define TOKEN_BUCKET_RATE_LIMITER_CORE_ASSERT_SVH

// Same-cycle implication, off while reset is asserted.
`define TBRL_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is asserted.
`define TBRL_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/tbrl_pkg.sv
// Shared constants, codes and types for the token bucket rate limiter.
package tbrl_pkg;

    localparam int TOKEN_BITS     = 32;
    localparam int RATE_FRAC_BITS = 32;
    localparam int TIME_BITS      = 48;
    localparam int RATE_BITS      = 48;

    localparam int PROD_BITS  = TIME_BITS + RATE_BITS;
    localparam int FIXED_BITS = TOKEN_BITS + RATE_FRAC_BITS;

    // Operand split for the partial-product multiplier
    localparam int TIME_LO_BITS = TIME_BITS / 2;
    localparam int TIME_HI_BITS = TIME_BITS - TIME_LO_BITS;
    localparam int RATE_LO_BITS = RATE_BITS / 2;
    localparam int RATE_HI_BITS = RATE_BITS - RATE_LO_BITS;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = RATE_BITS;

    localparam int QUEUE_DEPTH     = 2;
    localparam int QUEUE_PTR_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    // Three front stages, the queue and the output register
    localparam int IN_FLIGHT_MAX   = 3 + QUEUE_DEPTH + 1;
    localparam int IN_FLIGHT_BITS  = $clog2(IN_FLIGHT_MAX + 1);

    // One token per second, rounded
    localparam longint unsigned UsecPerSec = 64'd1000000;
    localparam logic [RATE_BITS-1:0] DEFAULT_RATE =
        RATE_BITS'(((64'd1 << RATE_FRAC_BITS) + (UsecPerSec / 64'd2)) / UsecPerSec);

    localparam logic [TOKEN_BITS-1:0] CAPACITY_RESET = TOKEN_BITS'(1);
    localparam logic [RATE_BITS-1:0]  RATE_RESET     = RATE_BITS'(4295);

    // Request operations
    localparam logic [1:0] OP_ACQUIRE = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RESET   = 2'd2;

    // Register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_CAPACITY    = CFG_INDEX_BITS'(0);
    localparam logic [CFG_INDEX_BITS-1:0] REG_REFILL_RATE = CFG_INDEX_BITS'(1);

    // Commands handed from front to back
    localparam logic [1:0] CMD_REPORT  = 2'd0;
    localparam logic [1:0] CMD_ACQUIRE = 2'd1;
    localparam logic [1:0] CMD_FILL    = 2'd2;

    typedef struct packed {
        logic [1:0]            cmd;
        logic                  refill;
        logic [TOKEN_BITS-1:0] count;
        logic [PROD_BITS-1:0]  credit;
    } tbrl_word_t;

endpackage

FILE: src/tbrl_front.sv
// Front end: accepts requests, tracks the timestamp, forms the refill credit.
module tbrl_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_operation,
    input  logic [tbrl_pkg::TOKEN_BITS-1:0] s_request_count,
    input  logic [tbrl_pkg::TIME_BITS-1:0]  s_timestamp,
    input  logic [tbrl_pkg::RATE_BITS-1:0]  refill_rate,
    output logic                           out_valid,
    input  logic                           out_ready,
    output tbrl_pkg::tbrl_word_t           out_word
);
    import tbrl_pkg::*;

    logic                  s_accept;
    logic                  refill_op;
    logic                  ts_nonzero;
    logic                  stamped;
    logic                  ahead;
    logic                  advance;
    logic [TIME_BITS-1:0]  elapsed;
    logic [1:0]            cmd;
    logic [TIME_BITS-1:0]  last_time_reg;
    logic [TIME_BITS-1:0]  last_time_next;

    logic rdy0, rdy1, rdy2;

    // Stage 0: classified request
    logic                  v0_reg;
    logic [1:0]            s0_cmd_reg;
    logic                  s0_refill_reg;
    logic [TOKEN_BITS-1:0] s0_count_reg;
    logic [TIME_BITS-1:0]  s0_elapsed_reg;
    logic [RATE_BITS-1:0]  s0_rate_reg;

    // Stage 1: partial products
    logic                  v1_reg;
    logic [1:0]            s1_cmd_reg;
    logic                  s1_refill_reg;
    logic [TOKEN_BITS-1:0] s1_count_reg;
    logic [TIME_LO_BITS+RATE_LO_BITS-1:0] pp_ll_reg;
    logic [TIME_LO_BITS+RATE_HI_BITS-1:0] pp_lh_reg;
    logic [TIME_HI_BITS+RATE_LO_BITS-1:0] pp_hl_reg;
    logic [TIME_HI_BITS+RATE_HI_BITS-1:0] pp_hh_reg;
    logic [TIME_LO_BITS+RATE_LO_BITS-1:0] pp_ll_next;
    logic [TIME_LO_BITS+RATE_HI_BITS-1:0] pp_lh_next;
    logic [TIME_HI_BITS+RATE_LO_BITS-1:0] pp_hl_next;
    logic [TIME_HI_BITS+RATE_HI_BITS-1:0] pp_hh_next;

    // Stage 2: full product
    logic                  v2_reg;
    tbrl_word_t            s2_word_reg;
    logic [PROD_BITS-1:0]  credit_next;

    assign rdy2     = !v2_reg || out_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign rdy0     = !v0_reg || rdy1;
    assign s_ready  = rdy0;
    assign s_accept = s_valid && rdy0;

    assign out_valid = v2_reg;
    assign out_word  = s2_word_reg;

    always_comb begin
        refill_op  = ((s_operation == OP_ACQUIRE) && (s_request_count != '0))
                     || (s_operation == OP_QUERY);
        ts_nonzero = (s_timestamp != '0);
        stamped    = (last_time_reg != '0);
        ahead      = (s_timestamp > last_time_reg);
        elapsed    = s_timestamp - last_time_reg;
        advance    = refill_op && ts_nonzero && stamped && ahead;

        last_time_next = last_time_reg;
        if (refill_op && ts_nonzero && (!stamped || ahead)) begin
            last_time_next = s_timestamp;
        end
        if (s_operation == OP_RESET) begin
            last_time_next = s_timestamp;
        end

        unique case (s_operation)
            OP_ACQUIRE: cmd = (s_request_count != '0) ? CMD_ACQUIRE : CMD_REPORT;
            OP_QUERY:   cmd = CMD_REPORT;
            OP_RESET:   cmd = CMD_FILL;
            default:    cmd = CMD_REPORT;
        endcase
    end

    always_comb begin
        pp_ll_next = {{RATE_LO_BITS{1'b0}}, s0_elapsed_reg[TIME_LO_BITS-1:0]}
                   * {{TIME_LO_BITS{1'b0}}, s0_rate_reg[RATE_LO_BITS-1:0]};
        pp_lh_next = {{RATE_HI_BITS{1'b0}}, s0_elapsed_reg[TIME_LO_BITS-1:0]}
                   * {{TIME_LO_BITS{1'b0}}, s0_rate_reg[RATE_BITS-1:RATE_LO_BITS]};
        pp_hl_next = {{RATE_LO_BITS{1'b0}}, s0_elapsed_reg[TIME_BITS-1:TIME_LO_BITS]}
                   * {{TIME_HI_BITS{1'b0}}, s0_rate_reg[RATE_LO_BITS-1:0]};
        pp_hh_next = {{RATE_HI_BITS{1'b0}}, s0_elapsed_reg[TIME_BITS-1:TIME_LO_BITS]}
                   * {{TIME_HI_BITS{1'b0}}, s0_rate_reg[RATE_BITS-1:RATE_LO_BITS]};

        credit_next = PROD_BITS'(pp_ll_reg)
                    + (PROD_BITS'(pp_lh_reg) << RATE_LO_BITS)
                    + (PROD_BITS'(pp_hl_reg) << TIME_LO_BITS)
                    + (PROD_BITS'(pp_hh_reg) << (TIME_LO_BITS + RATE_LO_BITS));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_time_reg <= '0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
        end else begin
            if (s_accept) begin
                last_time_reg <= last_time_next;
            end
            if (rdy0) begin
                v0_reg <= s_valid;
            end
            if (rdy1) begin
                v1_reg <= v0_reg;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s0_cmd_reg     <= cmd;
            s0_refill_reg  <= advance;
            s0_count_reg   <= s_request_count;
            s0_elapsed_reg <= elapsed;
            s0_rate_reg    <= (refill_rate == '0) ? DEFAULT_RATE : refill_rate;
        end
        if (rdy1 && v0_reg) begin
            s1_cmd_reg    <= s0_cmd_reg;
            s1_refill_reg <= s0_refill_reg;
            s1_count_reg  <= s0_count_reg;
            pp_ll_reg     <= pp_ll_next;
            pp_lh_reg     <= pp_lh_next;
            pp_hl_reg     <= pp_hl_next;
            pp_hh_reg     <= pp_hh_next;
        end
        if (rdy2 && v1_reg) begin
            s2_word_reg.cmd    <= s1_cmd_reg;
            s2_word_reg.refill <= s1_refill_reg;
            s2_word_reg.count  <= s1_count_reg;
            s2_word_reg.credit <= credit_next;
        end
    end

endmodule

FILE: src/tbrl_queue.sv
// Small FIFO between the front and back ends.
module tbrl_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 enq_valid,
    output logic                 enq_ready,
    input  tbrl_pkg::tbrl_word_t enq_word,
    output logic                 deq_valid,
    input  logic                 deq_ready,
    output tbrl_pkg::tbrl_word_t deq_word
);
    import tbrl_pkg::*;

    tbrl_word_t                mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_BITS-1:0] count_reg;
    logic                      push;
    logic                      pop;

    assign enq_ready = (count_reg != QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign deq_valid = (count_reg != '0);
    assign deq_word  = mem[rd_ptr_reg];
    assign push      = enq_valid && enq_ready;
    assign pop       = deq_valid && deq_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= enq_word;
        end
    end

endmodule

FILE: src/tbrl_back.sv
// Back end: applies the credit to the bucket and drives the result register.
module tbrl_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  tbrl_pkg::tbrl_word_t            in_word,
    input  logic [tbrl_pkg::TOKEN_BITS-1:0] capacity,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_granted,
    output logic [tbrl_pkg::TOKEN_BITS-1:0] m_available
);
    import tbrl_pkg::*;

    logic [TOKEN_BITS-1:0]     token_count_reg;
    logic [TOKEN_BITS-1:0]     token_count_next;
    logic [RATE_FRAC_BITS-1:0] fraction_reg;
    logic [RATE_FRAC_BITS-1:0] fraction_next;
    logic [TOKEN_BITS-1:0]     cap_eff;
    logic [FIXED_BITS:0]       sum;
    logic                      overflow;
    logic                      fill;
    logic [TOKEN_BITS-1:0]     tc_refilled;
    logic [RATE_FRAC_BITS-1:0] frac_refilled;
    logic                      granted_next;
    logic                      take;

    logic                      m_valid_reg;
    logic                      m_granted_reg;
    logic [TOKEN_BITS-1:0]     m_available_reg;

    assign in_ready    = !m_valid_reg || m_ready;
    assign take        = in_valid && in_ready;
    assign m_valid     = m_valid_reg;
    assign m_granted   = m_granted_reg;
    assign m_available = m_available_reg;

    always_comb begin
        cap_eff = (capacity == '0) ? TOKEN_BITS'(1) : capacity;

        // Bucket as a fixed-point word, whole tokens over the fraction
        sum      = {1'b0, token_count_reg, fraction_reg}
                 + {1'b0, in_word.credit[FIXED_BITS-1:0]};
        overflow = |in_word.credit[PROD_BITS-1:FIXED_BITS];
        fill     = overflow || (sum[FIXED_BITS:RATE_FRAC_BITS] >= {1'b0, cap_eff});

        tc_refilled   = token_count_reg;
        frac_refilled = fraction_reg;
        if (in_word.refill) begin
            if (fill) begin
                tc_refilled   = cap_eff;
                frac_refilled = '0;
            end else begin
                tc_refilled   = sum[FIXED_BITS-1:RATE_FRAC_BITS];
                frac_refilled = sum[RATE_FRAC_BITS-1:0];
            end
        end

        granted_next     = 1'b0;
        token_count_next = tc_refilled;
        fraction_next    = frac_refilled;
        unique case (in_word.cmd)
            CMD_ACQUIRE: begin
                if (tc_refilled >= in_word.count) begin
                    token_count_next = tc_refilled - in_word.count;
                    granted_next     = 1'b1;
                end
            end
            CMD_FILL: begin
                token_count_next = cap_eff;
                fraction_next    = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            token_count_reg <= CAPACITY_RESET;
            fraction_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (take) begin
                token_count_reg <= token_count_next;
                fraction_reg    <= fraction_next;
            end
            if (in_ready) begin
                m_valid_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            m_granted_reg   <= granted_next;
            m_available_reg <= token_count_next;
        end
    end

endmodule

FILE: src/token_bucket_rate_limiter_core.sv
// Top level of the token bucket rate limiter: config registers and the datapath.
//
//   channel   prefix   handshake          word
//   request   s_       s_valid/s_ready    operation, request_count, timestamp
//   result    m_       m_valid/m_ready    granted, available
//   config    cfg_     cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Throughput: one request per cycle while the result side is not stalled by m_ready.
// Registers from request accept to m_valid: classify, partial products, product sum,
// queue, result. The bucket update (fixed-point add, fill compare, acquire subtract)
// is a feedback loop closed in the back end; the front's timestamp is another loop.
// Reset (aresetn, synchronous) leaves a full bucket of capacity 1, unstamped.
// The front stalls only when the queue is full; the back only on m_ready.
module token_bucket_rate_limiter_core (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_operation,
    input  logic [tbrl_pkg::TOKEN_BITS-1:0]     s_request_count,
    input  logic [tbrl_pkg::TIME_BITS-1:0]      s_timestamp,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_granted,
    output logic [tbrl_pkg::TOKEN_BITS-1:0]     m_available,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tbrl_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [tbrl_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import tbrl_pkg::*;

    logic [TOKEN_BITS-1:0] capacity_reg;
    logic [RATE_BITS-1:0]  refill_rate_reg;

    // front -> queue
    logic       fq_valid;
    logic       fq_ready;
    tbrl_word_t fq_word;

    // queue -> back
    logic       qb_valid;
    logic       qb_ready;
    tbrl_word_t qb_word;

    // Config writes are always accepted; software must write only when idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg    <= CAPACITY_RESET;
            refill_rate_reg <= RATE_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_CAPACITY:    capacity_reg    <= cfg_data[TOKEN_BITS-1:0];
                REG_REFILL_RATE: refill_rate_reg <= cfg_data[RATE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    // Timestamp tracking and the elapsed * rate product
    tbrl_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_request_count (s_request_count),
        .s_timestamp     (s_timestamp),
        .refill_rate     (refill_rate_reg),
        .out_valid       (fq_valid),
        .out_ready       (fq_ready),
        .out_word        (fq_word)
    );

    // Decouples the multiplier pipeline from result backpressure
    tbrl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .enq_valid (fq_valid),
        .enq_ready (fq_ready),
        .enq_word  (fq_word),
        .deq_valid (qb_valid),
        .deq_ready (qb_ready),
        .deq_word  (qb_word)
    );

    // Token count and fraction live here
    tbrl_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (qb_valid),
        .in_ready    (qb_ready),
        .in_word     (qb_word),
        .capacity    (capacity_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_granted   (m_granted),
        .m_available (m_available)
    );

endmodule

FILE: src/tbrl_checker.sv
// Port-level checker for the token bucket rate limiter, bound to the top level.
`include "token_bucket_rate_limiter_core_assert.svh"

module tbrl_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_granted,
    input logic [tbrl_pkg::TOKEN_BITS-1:0] m_available
);
    import tbrl_pkg::*;

    logic [IN_FLIGHT_BITS-1:0] in_flight_reg;
    logic                      word_in;
    logic                      word_out;

    assign word_in  = s_valid && s_ready;
    assign word_out = m_valid && m_ready;

    // Requests accepted but not yet answered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= '0;
        end else if (word_in && !word_out) begin
            in_flight_reg <= in_flight_reg + 1'b1;
        end else if (word_out && !word_in) begin
            in_flight_reg <= in_flight_reg - 1'b1;
        end
    end

    `TBRL_ASSERT_NXT(a_result_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_granted) && $stable(m_available), "result changed while stalled")
    `TBRL_ASSERT_NXT(a_reset_idle, aclk, 1'b1, !aresetn, !m_valid, "result valid right after reset")
    `TBRL_ASSERT_IMP(a_no_phantom, aclk, aresetn, m_valid, in_flight_reg != '0, "result with no request outstanding")
    `TBRL_ASSERT_IMP(a_full_stall, aclk, aresetn, in_flight_reg == IN_FLIGHT_BITS'(IN_FLIGHT_MAX), !s_ready, "request taken with every slot full")

endmodule

bind token_bucket_rate_limiter_core tbrl_checker u_tbrl_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_granted   (m_granted),
    .m_available (m_available)
);

FILE: tb/sv/bucket_check_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class for the token bucket testbench: bucket predictor and result checks.
package bucket_check_pkg;
    import tbrl_pkg::*;

    // Operation code the block does not define; it must leave the bucket alone
    localparam logic [1:0] OP_UNDEFINED = 2'd3;

    // Rate used when the rate register holds zero: one token per second, rounded
    localparam logic [RATE_BITS-1:0] ONE_PER_SEC_RATE =
        RATE_BITS'(((64'd1 << RATE_FRAC_BITS) + 64'd500000) / 64'd1000000);

    typedef struct {
        logic                  granted;
        logic [TOKEN_BITS-1:0] available;
    } bucket_result_t;

    class bucket_scoreboard;
        logic [TOKEN_BITS-1:0]     capacity;
        logic [RATE_BITS-1:0]      rate;
        logic [TOKEN_BITS-1:0]     tokens;
        logic [RATE_FRAC_BITS-1:0] frac;
        logic [TIME_BITS-1:0]      last_ts;
        bucket_result_t            owed[$];
        int                        errors;
        int                        checked;
        int                        op_seen[4];
        int                        grants;
        int                        fills;
        int                        settings;

        function new();
            capacity = CAPACITY_RESET;
            rate     = RATE_RESET;
            tokens   = CAPACITY_RESET;
            frac     = '0;
            last_ts  = '0;
            errors   = 0;
            checked  = 0;
            grants   = 0;
            fills    = 0;
            settings = 1;
            foreach (op_seen[i]) op_seen[i] = 0;
        endfunction

        function logic [TOKEN_BITS-1:0] eff_capacity();
            return (capacity == '0) ? TOKEN_BITS'(1) : capacity;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_CAPACITY) begin
                capacity = data[TOKEN_BITS-1:0];
            end else if (idx == REG_REFILL_RATE) begin
                rate = data[RATE_BITS-1:0];
            end
        endfunction

        // Credit from elapsed time, exact in 128 bits; saturates at capacity
        function void refill(logic [TIME_BITS-1:0] ts);
            logic [127:0]           credit;
            logic [127:0]           whole;
            logic [RATE_BITS-1:0]   r;
            logic [TOKEN_BITS-1:0]  cap;
            logic [TOKEN_BITS-1:0]  room;
            if (ts == '0) return;
            if (last_ts == '0) begin
                last_ts = ts;
                return;
            end
            if (ts <= last_ts) return;
            r      = (rate == '0) ? ONE_PER_SEC_RATE : rate;
            credit = 128'(ts - last_ts) * 128'(r) + 128'(frac);
            whole  = credit >> RATE_FRAC_BITS;
            last_ts = ts;
            cap  = eff_capacity();
            room = (tokens >= cap) ? '0 : cap - tokens;
            if (whole >= 128'(room)) begin
                tokens = cap;
                frac   = '0;
                fills++;
            end else begin
                tokens = tokens + whole[TOKEN_BITS-1:0];
                frac   = credit[RATE_FRAC_BITS-1:0];
            end
        endfunction

        function void note_request(logic [1:0] op, logic [TOKEN_BITS-1:0] count,
                                   logic [TIME_BITS-1:0] ts);
            bucket_result_t res;
            res.granted = 1'b0;
            op_seen[op]++;
            case (op)
                OP_ACQUIRE: begin
                    if (count != '0) begin
                        refill(ts);
                        if (tokens >= count) begin
                            tokens = tokens - count;
                            res.granted = 1'b1;
                            grants++;
                        end
                    end
                end
                OP_QUERY: refill(ts);
                OP_RESET: begin
                    tokens  = eff_capacity();
                    frac    = '0;
                    last_ts = ts;
                end
                default: ;
            endcase
            res.available = tokens;
            owed.push_back(res);
        endfunction

        function void check_result(logic granted, logic [TOKEN_BITS-1:0] available);
            bucket_result_t want;
            if (owed.size() == 0) begin
                $error("result word with nothing owed: granted %0d available %0d",
                       granted, available);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (granted !== want.granted) begin
                $error("granted mismatch: expected %0d, actual %0d", want.granted, granted);
                errors++;
            end
            if (available !== want.available) begin
                $error("available mismatch: expected %0d, actual %0d",
                       want.available, available);
                errors++;
            end
        endfunction

        function int pending();
            return owed.size();
        endfunction
    endclass

endpackage

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench of the token bucket rate limiter core: stimulus, handshakes, checks.
module testbench;
    import tbrl_pkg::*;
    import bucket_check_pkg::*;

    // No accept on any channel for this many cycles means the block hung.
    // Slowest legit quiet stretch is a long receiver hold plus a long gap.
    localparam int WATCHDOG_LIMIT = 4000;
    // Five-stage pipe; settle time kept after the last result word
    localparam int SETTLE_CYCLES  = 12;
    localparam int LONG_HOLD      = 80;
    localparam int PHASES         = 7;
    localparam int PHASE_ITEMS    = 133;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;

    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [1:0]                s_operation = OP_ACQUIRE;
    logic [TOKEN_BITS-1:0]     s_request_count = '0;
    logic [TIME_BITS-1:0]      s_timestamp = '0;

    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_granted;
    logic [TOKEN_BITS-1:0]     m_available;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_CAPACITY;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    bucket_scoreboard sb = new();

    // Bucket settings swept by the random part: typical, zero (fallback), extremes
    logic [TOKEN_BITS-1:0] phase_cap  [PHASES] =
        '{32'd10, 32'd1000, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd5, 32'd64};
    logic [RATE_BITS-1:0]  phase_rate [PHASES] =
        '{48'h1_0000_0000, 48'h1000_0000, 48'd0, 48'hFFFF_FFFF_FFFF, 48'd1,
          48'h1_8000_0000, 48'd4295};

    // Microsecond clock that the stimulus walks forward
    logic [TIME_BITS-1:0] clock_us = '0;

    // Long receiver hold: main bumps the request count, receiver serves it
    int hold_requests = 0;
    int hold_served   = 0;
    int stall_left    = 0;
    int steady_left   = 0;
    int rx_roll;
    int quiet_cycles  = 0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    token_bucket_rate_limiter_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_request_count (s_request_count),
        .s_timestamp     (s_timestamp),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_granted       (m_granted),
        .m_available     (m_available),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    // Gap length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    // Watchdog: all outputs sampled at the edge, before the block updates them
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: check each accepted word, then pick next cycle's ready.
    // Random stalls, steady stretches, and the long hold on request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_granted, m_available);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                stall_left  = LONG_HOLD;
                steady_left = 0;
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else if (steady_left > 0) begin
                m_ready <= 1'b1;
                steady_left--;
            end else begin
                m_ready <= 1'b1;
                rx_roll = $urandom_range(0, 99);
                if (rx_roll < 8) begin
                    steady_left = $urandom_range(20, 60);
                end else if (rx_roll < 35) begin
                    stall_left = pick_gap() + 1;
                end
            end
        end
    end

    // Offer one request word; valid stays up from one word to the next unless
    // a gap is asked for. Returns at the edge where the word was taken.
    task automatic send_request(input logic [1:0] op, input logic [TOKEN_BITS-1:0] count,
                                input logic [TIME_BITS-1:0] ts, input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_operation     <= op;
        s_request_count <= count;
        s_timestamp     <= ts;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, count, ts);
    endtask

    // Stop offering and wait until every owed result word has come back
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (sb.pending() > 0);
    endtask

    // Register write; valid is left up for a following write, caller drops it
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, data);
    endtask

    task automatic set_bucket(input logic [TOKEN_BITS-1:0] cap,
                              input logic [RATE_BITS-1:0] rate);
        drain();
        write_reg(REG_CAPACITY, CFG_DATA_BITS'(cap));
        write_reg(REG_REFILL_RATE, CFG_DATA_BITS'(rate));
        cfg_valid <= 1'b0;
        sb.settings++;
    endtask

    // Next timestamp: mostly forward steps of widely varying size, plus failed
    // samples, repeats, backward moves, random jumps and the top of the range.
    function automatic logic [TIME_BITS-1:0] next_time();
        int                   r;
        logic [TIME_BITS:0]   sum;
        logic [TIME_BITS-1:0] step;
        r = $urandom_range(0, 79);
        if (r < 3) return '0;
        if (r < 6) return clock_us;
        if (r < 8) begin
            return (clock_us > 16) ? clock_us - TIME_BITS'($urandom_range(1, 16)) : clock_us;
        end
        if (r < 10) begin
            clock_us = {16'($urandom), 32'($urandom)};
            return clock_us;
        end
        if (r == 10) return TIME_MAX;
        case ($urandom_range(0, 9)) inside
            [0:3]:   step = TIME_BITS'($urandom_range(1, 8));
            [4:5]:   step = TIME_BITS'($urandom_range(1, 4000));
            [6:7]:   step = TIME_BITS'($urandom_range(1, 2000000));
            8:       step = TIME_BITS'($urandom);
            default: step = {8'($urandom), 32'($urandom)};
        endcase
        sum = {1'b0, clock_us} + {1'b0, step};
        if (sum[TIME_BITS]) begin
            clock_us = TIME_BITS'($urandom_range(1, 1000));
        end else begin
            clock_us = sum[TIME_BITS-1:0];
        end
        return clock_us;
    endfunction

    // One random request, counts scaled to the current capacity
    task automatic send_random(input int gap);
        logic [1:0]            op;
        logic [TOKEN_BITS-1:0] count;
        logic [TOKEN_BITS-1:0] cap;
        int                    r;
        cap = sb.eff_capacity();
        r = $urandom_range(0, 99);
        if (r < 4)       op = OP_RESET;
        else if (r < 6)  op = OP_UNDEFINED;
        else if (r < 28) op = OP_QUERY;
        else             op = OP_ACQUIRE;
        r = $urandom_range(0, 19);
        if (r == 0)      count = '0;
        else if (r == 1) count = $urandom;
        else if (r == 2) count = cap;
        else if (r < 6)  count = $urandom_range(1, cap);
        else             count = $urandom_range(1, (cap < 16) ? cap : 16);
        send_request(op, count, next_time(), gap);
    endtask

    initial begin
        int burst_left;
        burst_left = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part, reset settings: capacity 1, about one token per second
        send_request(OP_QUERY, '0, '0, 0);              // failed sample, stays unstamped
        send_request(OP_ACQUIRE, 32'd1, 48'd100, 0);    // first stamp only, takes the token
        send_request(OP_ACQUIRE, 32'd1, 48'd100, 0);    // time did not move: denied
        send_request(OP_ACQUIRE, '0, 48'd5000000, 0);   // zero count skips the refill
        send_request(OP_QUERY, '0, 48'd50, 0);          // time went backwards
        send_request(OP_QUERY, '0, 48'd1000100, 1);     // one second later: one token back
        send_request(OP_ACQUIRE, '1, TIME_MAX, 0);      // largest count and time: denied
        send_request(OP_UNDEFINED, 32'h5A5A_A5A5, 48'hA5A5_5A5A_F00F, 0);
        send_request(OP_RESET, '0, '0, 2);              // full, but left unstamped
        send_request(OP_ACQUIRE, 32'd1, '0, 0);         // failed sample, grant from full
        send_request(OP_QUERY, '1, TIME_MAX, 0);        // stamps only
        send_request(OP_QUERY, '0, 48'd1, 0);           // before the stamp: no change

        // Capacity lowered under the stored count, with 1 token/us
        set_bucket(32'd1000, 48'h1_0000_0000);
        send_request(OP_RESET, '0, 48'd10, 0);
        send_request(OP_ACQUIRE, 32'd400, 48'd10, 0);
        send_request(OP_ACQUIRE, 32'd601, 48'd11, 0);   // exactly enough after one refill
        send_request(OP_QUERY, '0, 48'd300, 0);
        drain();
        write_reg(REG_CAPACITY, CFG_DATA_BITS'(3));
        cfg_valid <= 1'b0;
        send_request(OP_QUERY, '0, 48'd300, 0);         // stored count still reported
        send_request(OP_ACQUIRE, 32'd200, 48'd300, 0);
        send_request(OP_QUERY, '0, 48'd301, 0);         // advancing refill clamps to 3
        send_request(OP_ACQUIRE, 32'd3, 48'd301, 0);
        clock_us = 48'd301;

        // Random part: one phase per bucket setting, mostly opened by a reset
        for (int p = 0; p < PHASES; p++) begin
            set_bucket(phase_cap[p], phase_rate[p]);
            if (p == 0 || $urandom_range(0, 3) != 0) begin
                clock_us = TIME_BITS'($urandom_range(1, 1 << 20));
                send_request(OP_RESET, $urandom, clock_us, 0);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                // Long result-side hold while words keep coming: block backs up
                if (i == 20) begin
                    hold_requests++;
                    burst_left = 40;
                end
                if (burst_left == 0 && $urandom_range(0, 99) == 0) drain();
                if (burst_left > 0) begin
                    burst_left--;
                    send_random(0);
                end else begin
                    send_random(pick_gap());
                end
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d acquires (%0d granted), %0d queries, %0d resets,",
                 sb.op_seen[OP_ACQUIRE], sb.grants, sb.op_seen[OP_QUERY],
                 sb.op_seen[OP_RESET]);
        $display("%0d undefined ops over %0d bucket settings; %0d words checked, %0d fills",
                 sb.op_seen[OP_UNDEFINED], sb.settings, sb.checked, sb.fills);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/tbrl_pkg.sv
src/tbrl_front.sv
src/tbrl_queue.sv
src/tbrl_back.sv
src/token_bucket_rate_limiter_core.sv
src/tbrl_checker.sv
tb/sv/bucket_check_pkg.sv
tb/sv/testbench.sv
